>>> hw/rtl/cud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cud_pkg
// shared types and constants of the usb record deframer
// ----------------------------------------------------------------------------
package cud_pkg;

    localparam int unsigned RecordLen  = 17;
    localparam int unsigned StoreDepth = RecordLen - 1;
    localparam int unsigned PosW       = 5;

    // control byte bits
    localparam int unsigned CtrlErrBit  = 7;
    localparam int unsigned CtrlPortBit = 4;

    // id word bits
    localparam int unsigned IdExtBit = 31;
    localparam int unsigned IdRtrBit = 30;

    localparam logic [PosW-1:0] PosLast = PosW'(StoreDepth);

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_ERROR = 1'b1
    } t_kind;

    // bytes 0..15 of the current record
    typedef logic [StoreDepth-1:0][7:0] t_store;

    // collector status toward the decoder and the top
    typedef struct packed {
        logic at_last;   // next byte completes a record
        logic complete;  // accepted byte completes a record this cycle
    } t_col_status;

    typedef struct packed {
        logic [7:0]  tx_errors;
        logic [7:0]  rx_errors;
        logic [7:0]  error_code;
        logic [63:0] payload;
        logic [3:0]  data_len;
        logic        remote;
        logic        extended;
        logic [29:0] frame_id;
        logic [31:0] timestamp;
        logic        port;
        t_kind       kind;
    } t_record;

endpackage

>>> hw/rtl/cud_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cud_collector
// byte position counter and store for the first sixteen record bytes
// ----------------------------------------------------------------------------
module cud_collector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output cud_pkg::t_store      o_store,
    output cud_pkg::t_col_status o_status
);
    import cud_pkg::*;

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    t_store          r_store;
    logic            w_at_last;

    assign w_at_last = (r_pos == PosLast);

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (w_at_last || i_last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // payload store, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && !w_at_last) begin
            r_store[r_pos[PosW-2:0]] <= i_byte;
        end
    end

    assign o_store          = r_store;
    assign o_status.at_last  = w_at_last;
    assign o_status.complete = i_accept && w_at_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosLast)
        else $error("byte position past record end");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (w_at_last || i_last)) |=> (r_pos == '0))
        else $error("position did not return to zero");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !w_at_last && !i_last) |=> (r_pos == $past(r_pos) + PosW'(1)))
        else $error("position did not advance");

endmodule

>>> hw/rtl/cud_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cud_decoder
// field decode of a finished record into the result register
// ----------------------------------------------------------------------------
module cud_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cud_pkg::t_store      i_store,
    input  logic [7:0]           i_final_byte,
    input  cud_pkg::t_col_status i_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output cud_pkg::t_record     o_record
);
    import cud_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_record r_rec;
    t_record n_rec;

    logic [7:0]  w_ctrl;
    logic [31:0] w_idw;
    logic        w_err;

    assign w_ctrl = i_store[8];
    assign w_idw  = {i_store[7], i_store[6], i_store[5], i_store[4]};
    assign w_err  = w_ctrl[CtrlErrBit];

    always_comb begin
        n_rec           = '0;
        n_rec.kind      = w_err ? KIND_ERROR : KIND_DATA;
        n_rec.port      = w_ctrl[CtrlPortBit];
        n_rec.timestamp = {i_store[3], i_store[2], i_store[1], i_store[0]};
        if (w_err) begin
            n_rec.error_code = i_store[9];
            n_rec.rx_errors  = i_store[10];
            n_rec.tx_errors  = i_store[11];
        end else begin
            n_rec.frame_id = w_idw[29:0];
            n_rec.extended = w_idw[IdExtBit];
            n_rec.remote   = w_idw[IdRtrBit];
            n_rec.data_len = w_ctrl[3:0];
            n_rec.payload  = {i_final_byte, i_store[15], i_store[14], i_store[13],
                              i_store[12], i_store[11], i_store[10], i_store[9]};
        end
    end

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        if (i_status.complete) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_status.complete) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid = r_valid;
    assign o_record    = r_rec;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.complete |-> (!r_valid || i_out_ready))
        else $error("pending result overwritten");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.complete |=> r_valid)
        else $error("finished record not presented");

endmodule

>>> hw/rtl/can_usb_record_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_usb_record_deframer
// groups bulk transfer bytes into 17-byte records and decodes each record
// ----------------------------------------------------------------------------
//  channel   dir   request                         fields
//  s         in    one byte of the transfer        tdata: rx_byte, tlast: end_of_transfer
//  m         out   one decoded record              tdata: record fields, tuser: kind
//
//  one byte accepted per cycle, unless a record-completing byte must wait; the 17th byte of a record loads the result
//  register directly, so a record appears in the cycle after its last byte
//  the byte counter and result valid clear on synchronous reset; the byte
//  store is written before it is read and needs no clearing
//  while a result waits, bytes that do not finish a record are still taken;
//  only a record-completing byte waits for the result register to free up
//  tlast on a byte that does not finish a record drops the partial record
// ----------------------------------------------------------------------------
module can_usb_record_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] rx_byte
    input  logic         i_s_tlast,   // end_of_transfer
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // port, timestamp, frame_id, extended, remote,
                                      // data_len, payload, error_code, rx_errors,
                                      // tx_errors, zero pad
    output logic [0:0]   o_m_tuser    // kind
);
    import cud_pkg::*;

    t_store      w_store;
    t_col_status w_status;
    t_record     w_rec;
    logic        w_accept;
    logic        w_out_valid;

    // a completing byte needs a free (or draining) result register
    assign o_s_tready = !w_status.at_last || !w_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    cud_collector u_collector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_store  (w_store),
        .o_status (w_status)
    );

    cud_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_store      (w_store),
        .i_final_byte (i_s_tdata),
        .i_status     (w_status),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (w_out_valid),
        .o_record     (w_rec)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tuser  = w_rec.kind;

    // pack fields from the lowest bit up
    assign o_m_tdata = {3'b000,
                        w_rec.tx_errors,
                        w_rec.rx_errors,
                        w_rec.error_code,
                        w_rec.payload,
                        w_rec.data_len,
                        w_rec.remote,
                        w_rec.extended,
                        w_rec.frame_id,
                        w_rec.timestamp,
                        w_rec.port};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the usb record deframer: bytes of bulk transfers
// go in on the slave side, a local model groups them into 17-byte records and
// predicts each decoded data frame or error report, and every result on the
// master side is compared field by field under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;
    import cud_pkg::*;

    localparam int unsigned StallLimit = 4000;  // cycles without any request
    localparam int unsigned SettleCycles = 20;
    localparam int unsigned PhaseBytes = 150;
    localparam int unsigned MaxReports = 10;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] rx_byte
    logic         s_tlast;   // end_of_transfer
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // port, timestamp, frame_id, extended, remote, data_len,
                             // payload, error_code, rx_errors, tx_errors, zero pad
    logic [0:0]   m_tuser;   // kind

    // idle mix of the current phase, in percent
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // local copy of the deframer state
    logic [7:0]  rec_store [StoreDepth];
    int unsigned rec_pos;
    t_record     expected_records [$];

    int unsigned err_count;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;

    can_usb_record_deframer DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // model of one accepted byte: store it, or decode a finished record
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        t_record    rec;
        logic [7:0] ctrl;
        if (rec_pos < StoreDepth) begin
            rec_store[rec_pos] = b;
            rec_pos++;
        end else begin
            ctrl = rec_store[8];
            rec = '0;
            rec.kind = ctrl[CtrlErrBit] ? KIND_ERROR : KIND_DATA;
            rec.port = ctrl[CtrlPortBit];
            rec.timestamp = {rec_store[3], rec_store[2], rec_store[1], rec_store[0]};
            if (rec.kind == KIND_DATA) begin
                rec.frame_id = {rec_store[7][5:0], rec_store[6], rec_store[5], rec_store[4]};
                rec.extended = rec_store[7][IdExtBit-24];
                rec.remote   = rec_store[7][IdRtrBit-24];
                rec.data_len = ctrl[3:0];
                // last byte of the record is taken straight from the bus
                rec.payload  = {b, rec_store[15], rec_store[14], rec_store[13],
                                rec_store[12], rec_store[11], rec_store[10], rec_store[9]};
            end else begin
                rec.error_code = rec_store[9];
                rec.rx_errors  = rec_store[10];
                rec.tx_errors  = rec_store[11];
            end
            expected_records.push_back(rec);
            rec_pos = 0;
        end
        // end of transfer drops any partial record
        if (last) begin
            rec_pos = 0;
        end
    endtask

    // one byte request; called at a falling edge and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        deframe_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // one full record with random content; error flag set about a third of the time
    task automatic send_record(input logic last_at_end);
        logic [7:0] b;
        for (int i = 0; i < RecordLen; i++) begin
            b = 8'($urandom);
            if (i == 8) begin
                b[CtrlErrBit] = ($urandom_range(9) < 3);
            end
            send_byte(b, last_at_end && (i == RecordLen - 1));
        end
    endtask

    // transfer that stops short of a full record
    task automatic send_partial(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(8'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (expected_records.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned start;
        int unsigned pick;
        int unsigned nrec;
        logic        tail;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < PhaseBytes) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                // well-formed transfer, sometimes with a dangling partial record
                nrec = $urandom_range(1, 3);
                tail = ($urandom_range(3) == 0);
                for (int unsigned r = 0; r < nrec; r++) begin
                    send_record(!tail && (r == nrec - 1));
                end
                if (tail) begin
                    send_partial($urandom_range(1, StoreDepth));
                end
            end else if (pick < 85) begin
                send_partial($urandom_range(1, StoreDepth));
            end else begin
                // noise, may leave the record alignment off
                repeat ($urandom_range(1, 20)) begin
                    send_byte(8'($urandom), $urandom_range(19) == 0);
                end
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // extremes: all-ones data frame ended by its own last byte, an error
    // report, then a transfer that ends one byte short of a record
    task automatic test_directed();
        logic [7:0] b;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < RecordLen; i++) begin
            b = (i == 8) ? 8'h1f : 8'hff;
            send_byte(b, i == RecordLen - 1);
        end
        for (int i = 0; i < RecordLen; i++) begin
            case (i)
                8:          b = 8'h80;
                9, 10, 11:  b = 8'hff;
                default:    b = 8'h00;
            endcase
            send_byte(b, 1'b0);
        end
        for (int i = 0; i < StoreDepth; i++) begin
            send_byte(8'h00, i == StoreDepth - 1);
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_no_idle();
        run_random_phase(0, 0);
    endtask

    task automatic test_sender_idle();
        run_random_phase(62, 0);
    endtask

    task automatic test_receiver_stall();
        run_random_phase(0, 62);
    endtask

    task automatic test_both_idle();
        run_random_phase(7, 7);
    endtask

    // receiver back-pressure, changed at the falling edge
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic show_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("  %s: expected %h, got %h", name, want, got);
        end
    endtask

    // compare each result with the oldest predicted record
    always @(posedge clk) begin : check_results
        t_record want;
        t_record got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind       = t_kind'(m_tuser[0]);
            got.port       = m_tdata[0];
            got.timestamp  = m_tdata[32:1];
            got.frame_id   = m_tdata[62:33];
            got.extended   = m_tdata[63];
            got.remote     = m_tdata[64];
            got.data_len   = m_tdata[68:65];
            got.payload    = m_tdata[132:69];
            got.error_code = m_tdata[140:133];
            got.rx_errors  = m_tdata[148:141];
            got.tx_errors  = m_tdata[156:149];
            if (expected_records.size() == 0) begin
                err_count++;
                if (err_count <= MaxReports) begin
                    $display("record with none outstanding at %0t", $realtime);
                end
            end else begin
                want = expected_records.pop_front();
                if (want !== got) begin
                    err_count++;
                    if (err_count <= MaxReports) begin
                        $display("record mismatch at %0t", $realtime);
                        show_field("kind", 64'(want.kind), 64'(got.kind));
                        show_field("port", 64'(want.port), 64'(got.port));
                        show_field("timestamp", 64'(want.timestamp), 64'(got.timestamp));
                        show_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
                        show_field("extended", 64'(want.extended), 64'(got.extended));
                        show_field("remote", 64'(want.remote), 64'(got.remote));
                        show_field("data_len", 64'(want.data_len), 64'(got.data_len));
                        show_field("payload", want.payload, got.payload);
                        show_field("error_code", 64'(want.error_code), 64'(got.error_code));
                        show_field("rx_errors", 64'(want.rx_errors), 64'(got.rx_errors));
                        show_field("tx_errors", 64'(want.tx_errors), 64'(got.tx_errors));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any request on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= StallLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rec_pos        = 0;
        err_count      = 0;
        bytes_sent     = 0;
        quiet_cycles   = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        repeat (SettleCycles) @(posedge clk);
        if (expected_records.size() != 0) begin
            err_count++;
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
